[hdl/logic_analyzer_command_decoder_top_defines.svh]
// ----------------------------------------------------------------------------
// Logic analyser command decoder: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LOGIC_ANALYZER_COMMAND_DECODER_TOP_DEFINES_SVH
`define LOGIC_ANALYZER_COMMAND_DECODER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LACD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LACD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/lacd_pkg.sv]
// ----------------------------------------------------------------------------
// Logic analyser command decoder package
// Opcodes, event codes and the structures passed between the decoder modules.
// ----------------------------------------------------------------------------
package lacd_pkg;

  localparam int NumStages = 4;

  localparam logic [7:0] OpReset   = 8'h00;
  localparam logic [7:0] OpRun     = 8'h01;
  localparam logic [7:0] OpId      = 8'h02;
  localparam logic [7:0] OpMeta    = 8'h04;
  localparam logic [7:0] OpDivider = 8'h80;
  localparam logic [7:0] OpCounts  = 8'h81;
  localparam logic [7:0] OpFlags   = 8'h82;
  localparam logic [7:0] OpTrigMsk = 8'hC0;
  localparam logic [7:0] OpTrigVal = 8'hC1;
  localparam logic [7:0] OpTrigCfg = 8'hC2;
  localparam logic [7:0] OpKindMsk = 8'hF3;

  typedef enum logic [3:0] {
    EV_PENDING   = 4'd0,
    EV_RESET     = 4'd1,
    EV_RUN       = 4'd2,
    EV_ID        = 4'd3,
    EV_META      = 4'd4,
    EV_DIVIDER   = 4'd5,
    EV_COUNTS    = 4'd6,
    EV_FLAGS     = 4'd7,
    EV_TRIGMASK  = 4'd8,
    EV_TRIGVALUE = 4'd9,
    EV_TRIGCFG   = 4'd10,
    EV_UNK_SHORT = 4'd11,
    EV_UNK_LONG  = 4'd12
  } ev_e;

  typedef enum logic [1:0] {
    FR_PEND  = 2'd0,
    FR_SHORT = 2'd1,
    FR_LONG  = 2'd2
  } frame_kind_e;

  typedef struct packed {
    frame_kind_e kind;
    logic [7:0]  opcode;
    logic [31:0] word;
  } frame_t;

  typedef struct packed {
    ev_e         event_res;
    logic [1:0]  stage;
    logic [31:0] arg_value;
    logic [1:0]  trig_level;
    logic [4:0]  trig_channel;
    logic        trig_serial;
    logic        trig_start;
    logic [3:0]  group_off;
    logic [3:0]  flag_bits;
    logic        rle_on;
  } res_t;

endpackage

[hdl/logic_analyzer_command_decoder_top.sv]
// Each byte is registered in the input byte register, then decoded into the result register.
// Throughput: one byte per cycle unless the output stalls; each byte gives one result.
// Each register stage accepts a new transaction whenever the stage after it can move.
// Reset clears the valid flags and the byte position; no other state needs it.
// ----------------------------------------------------------------------------
// Logic analyser command decoder top level
// Receives command stream bytes and reports one decoded event per byte.
// ----------------------------------------------------------------------------
`include "logic_analyzer_command_decoder_top_defines.svh"

module logic_analyzer_command_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  event_res_o,
  output logic [1:0]  stage_o,
  output logic [31:0] arg_value_o,
  output logic [1:0]  trig_level_o,
  output logic [4:0]  trig_channel_o,
  output logic        trig_serial_o,
  output logic        trig_start_o,
  output logic [3:0]  group_off_o,
  output logic [3:0]  flag_bits_o,
  output logic        rle_on_o
);

  logic             s1_valid_q, s1_valid_d;
  logic [7:0]       s1_byte_q;
  logic             out_valid_q, out_valid_d;
  lacd_pkg::res_t   res_q, res_d;
  lacd_pkg::frame_t frame;
  logic             s1_adv;
  logic             in_acc;

  assign s1_adv      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_adv;
  assign in_acc      = in_valid_i && in_ready_o;
  assign s1_valid_d  = in_acc || (s1_valid_q && !s1_adv);
  assign out_valid_d = s1_adv || (out_valid_q && !out_ready_i);

  lacd_frame u_frame (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (s1_adv),
    .byte_i  (s1_byte_q),
    .frame_o (frame)
  );

  lacd_decode u_decode (
    .frame_i (frame),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= rx_byte_i;
    end
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_res_o    = 4'(res_q.event_res);
  assign stage_o        = res_q.stage;
  assign arg_value_o    = res_q.arg_value;
  assign trig_level_o   = res_q.trig_level;
  assign trig_channel_o = res_q.trig_channel;
  assign trig_serial_o  = res_q.trig_serial;
  assign trig_start_o   = res_q.trig_start;
  assign group_off_o    = res_q.group_off;
  assign flag_bits_o    = res_q.flag_bits;
  assign rle_on_o       = res_q.rle_on;

  `LACD_ASSERT_NXT(a_s1_hold, s1_valid_q && !s1_adv, s1_valid_q && $stable(s1_byte_q),
                   "held input byte lost or changed")
  `LACD_ASSERT_IMP(a_stage_trig, out_valid_q && res_q.stage != 2'd0,
                   res_q.event_res == lacd_pkg::EV_TRIGMASK ||
                   res_q.event_res == lacd_pkg::EV_TRIGVALUE ||
                   res_q.event_res == lacd_pkg::EV_TRIGCFG,
                   "stage set on a non-trigger event")
  `LACD_ASSERT_IMP(a_cfg_fields, out_valid_q && res_q.event_res != lacd_pkg::EV_TRIGCFG,
                   res_q.trig_level == 2'd0 && res_q.trig_channel == 5'd0 &&
                   !res_q.trig_serial && !res_q.trig_start,
                   "trigger configuration fields set on another event")

endmodule

[hdl/lacd_frame.sv]
// ----------------------------------------------------------------------------
// Logic analyser command decoder: command framing
// Tracks the byte position, holds a long opcode and gathers its four argument
// bytes, least significant first, reporting when a command is complete.
// ----------------------------------------------------------------------------
`include "logic_analyzer_command_decoder_top_defines.svh"

module lacd_frame (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic [7:0]      byte_i,
  output lacd_pkg::frame_t frame_o
);

  logic [2:0]  pos_q, pos_d;
  logic [7:0]  op_q, op_d;
  logic [31:0] word_q, word_d;
  logic [1:0]  lane;
  logic [31:0] word_next;

  assign lane      = 2'(pos_q - 3'd1);
  assign word_next = word_q | (32'(byte_i) << {lane, 3'b000});

  always_comb begin
    frame_o.kind   = lacd_pkg::FR_PEND;
    frame_o.opcode = op_q;
    frame_o.word   = word_next;
    pos_d          = pos_q;
    op_d           = op_q;
    word_d         = word_q;
    priority if (pos_q == 3'd0) begin
      frame_o.word = '0;
      if (!byte_i[7]) begin
        frame_o.kind   = lacd_pkg::FR_SHORT;
        frame_o.opcode = byte_i;
      end else begin
        pos_d  = 3'd1;
        op_d   = byte_i;
        word_d = '0;
      end
    end else if (pos_q == 3'd4) begin
      frame_o.kind = lacd_pkg::FR_LONG;
      pos_d        = 3'd0;
    end else begin
      pos_d  = pos_q + 3'd1;
      word_d = word_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 3'd0;
    end else if (adv_i) begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      op_q   <= op_d;
      word_q <= word_d;
    end
  end

  `LACD_ASSERT_IMP(a_pos_range, 1'b1, pos_q <= 3'd4, "byte position out of range")
  `LACD_ASSERT_IMP(a_op_long, pos_q != 3'd0, op_q[7], "argument bytes without long opcode")
  `LACD_ASSERT_NXT(a_pos_wrap, adv_i && pos_q == 3'd4, pos_q == 3'd0,
                   "position did not return to opcode")

endmodule

[hdl/lacd_decode.sv]
// ----------------------------------------------------------------------------
// Logic analyser command decoder: command decode
// Turns a framed command into one event with its decoded argument fields.
// ----------------------------------------------------------------------------
module lacd_decode (
  input  lacd_pkg::frame_t frame_i,
  output lacd_pkg::res_t   res_o
);

  logic [7:0] b1, b2, b3, b4;
  logic [1:0] st;
  logic [7:0] kind;
  logic       trig;

  assign b1   = frame_i.word[7:0];
  assign b2   = frame_i.word[15:8];
  assign b3   = frame_i.word[23:16];
  assign b4   = frame_i.word[31:24];
  assign st   = frame_i.opcode[3:2];
  assign kind = frame_i.opcode & lacd_pkg::OpKindMsk;
  assign trig = (kind == lacd_pkg::OpTrigMsk || kind == lacd_pkg::OpTrigVal ||
                 kind == lacd_pkg::OpTrigCfg) && (int'(st) < lacd_pkg::NumStages);

  always_comb begin
    res_o           = '0;
    res_o.event_res = lacd_pkg::EV_PENDING;
    unique case (frame_i.kind)
      lacd_pkg::FR_SHORT: begin
        unique case (frame_i.opcode)
          lacd_pkg::OpReset: res_o.event_res = lacd_pkg::EV_RESET;
          lacd_pkg::OpRun:   res_o.event_res = lacd_pkg::EV_RUN;
          lacd_pkg::OpId:    res_o.event_res = lacd_pkg::EV_ID;
          lacd_pkg::OpMeta:  res_o.event_res = lacd_pkg::EV_META;
          default:           res_o.event_res = lacd_pkg::EV_UNK_SHORT;
        endcase
      end
      lacd_pkg::FR_LONG: begin
        priority if (frame_i.opcode == lacd_pkg::OpDivider) begin
          res_o.event_res = lacd_pkg::EV_DIVIDER;
          res_o.arg_value = {8'h00, frame_i.word[23:0]};
        end else if (frame_i.opcode == lacd_pkg::OpCounts) begin
          res_o.event_res = lacd_pkg::EV_COUNTS;
          res_o.arg_value = frame_i.word;
        end else if (frame_i.opcode == lacd_pkg::OpFlags) begin
          res_o.event_res = lacd_pkg::EV_FLAGS;
          res_o.group_off = b1[5:2];
          res_o.flag_bits = {b1[7:6], b1[1:0]};
          res_o.rle_on    = b2[0];
        end else if (trig && kind == lacd_pkg::OpTrigMsk) begin
          res_o.event_res = lacd_pkg::EV_TRIGMASK;
          res_o.stage     = st;
          res_o.arg_value = frame_i.word;
        end else if (trig && kind == lacd_pkg::OpTrigVal) begin
          res_o.event_res = lacd_pkg::EV_TRIGVALUE;
          res_o.stage     = st;
          res_o.arg_value = frame_i.word;
        end else if (trig) begin
          res_o.event_res    = lacd_pkg::EV_TRIGCFG;
          res_o.stage        = st;
          res_o.arg_value    = {16'h0000, b2, b1};
          res_o.trig_level   = b3[1:0];
          res_o.trig_channel = {b4[0], b3[7:4]};
          res_o.trig_serial  = b4[2];
          res_o.trig_start   = b4[3];
        end else begin
          res_o.event_res = lacd_pkg::EV_UNK_LONG;
          res_o.arg_value = frame_i.word;
        end
      end
      default: begin
        res_o.event_res = lacd_pkg::EV_PENDING;
      end
    endcase
  end

endmodule

[tb/tb_logic_analyzer_command_decoder_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Logic analyser command decoder testbench
// Sends command stream bytes, directed then random, under several mixes of
// sender gaps and receiver stalls. It decodes each accepted byte into the
// expected event and checks every result transaction field by field.
// ----------------------------------------------------------------------------
module tb_logic_analyzer_command_decoder_top;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [3:0]  event_res_o;
  logic [1:0]  stage_o;
  logic [31:0] arg_value_o;
  logic [1:0]  trig_level_o;
  logic [4:0]  trig_channel_o;
  logic        trig_serial_o;
  logic        trig_start_o;
  logic [3:0]  group_off_o;
  logic [3:0]  flag_bits_o;
  logic        rle_on_o;

  logic [2:0]  arg_pos;
  logic [7:0]  held_op;
  logic [31:0] arg_word;
  logic [23:0] divider_q;
  logic [31:0] counts_q;
  logic [8:0]  flags_q;
  logic [31:0] mask_q [lacd_pkg::NumStages];
  logic [31:0] value_q [lacd_pkg::NumStages];
  logic [24:0] setup_q [lacd_pkg::NumStages];

  lacd_pkg::res_t expected_events [$];
  lacd_pkg::res_t want_res;
  int   gap_pct;
  int   stall_pct;
  int   mismatches;
  int   results_checked;
  int   bytes_sent;
  int   commands_sent;

  logic_analyzer_command_decoder_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_res_o    (event_res_o),
    .stage_o        (stage_o),
    .arg_value_o    (arg_value_o),
    .trig_level_o   (trig_level_o),
    .trig_channel_o (trig_channel_o),
    .trig_serial_o  (trig_serial_o),
    .trig_start_o   (trig_start_o),
    .group_off_o    (group_off_o),
    .flag_bits_o    (flag_bits_o),
    .rle_on_o       (rle_on_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("logic_analyzer_command_decoder_top test failed");
    $finish;
  end

  function automatic lacd_pkg::res_t decode_byte(input logic [7:0] b);
    lacd_pkg::res_t r;
    logic [7:0]  kind;
    logic [1:0]  st;
    logic [31:0] w;
    logic        trig;
    int          shift;
    r = '0;
    r.event_res = lacd_pkg::EV_PENDING;
    if (arg_pos == 3'd0) begin
      if (b[7] == 1'b0) begin
        case (b)
          lacd_pkg::OpReset: r.event_res = lacd_pkg::EV_RESET;
          lacd_pkg::OpRun:   r.event_res = lacd_pkg::EV_RUN;
          lacd_pkg::OpId:    r.event_res = lacd_pkg::EV_ID;
          lacd_pkg::OpMeta:  r.event_res = lacd_pkg::EV_META;
          default:           r.event_res = lacd_pkg::EV_UNK_SHORT;
        endcase
      end else begin
        held_op  = b;
        arg_word = '0;
        arg_pos  = 3'd1;
      end
      return r;
    end
    shift = 8 * (int'(arg_pos) - 1);
    arg_word[shift +: 8] = b;
    if (arg_pos < 3'd4) begin
      arg_pos = arg_pos + 3'd1;
      return r;
    end
    arg_pos = 3'd0;
    w    = arg_word;
    kind = held_op & lacd_pkg::OpKindMsk;
    st   = held_op[3:2];
    trig = (kind == lacd_pkg::OpTrigMsk || kind == lacd_pkg::OpTrigVal ||
            kind == lacd_pkg::OpTrigCfg) && (int'(st) < lacd_pkg::NumStages);
    if (held_op == lacd_pkg::OpDivider) begin
      divider_q   = w[23:0];
      r.event_res = lacd_pkg::EV_DIVIDER;
      r.arg_value = {8'd0, w[23:0]};
    end else if (held_op == lacd_pkg::OpCounts) begin
      counts_q    = w;
      r.event_res = lacd_pkg::EV_COUNTS;
      r.arg_value = w;
    end else if (held_op == lacd_pkg::OpFlags) begin
      flags_q     = {w[8], w[7:0]};
      r.event_res = lacd_pkg::EV_FLAGS;
      r.group_off = w[5:2];
      r.flag_bits = {w[7:6], w[1:0]};
      r.rle_on    = w[8];
    end else if (trig && kind == lacd_pkg::OpTrigMsk) begin
      mask_q[st]  = w;
      r.event_res = lacd_pkg::EV_TRIGMASK;
      r.stage     = st;
      r.arg_value = w;
    end else if (trig && kind == lacd_pkg::OpTrigVal) begin
      value_q[st] = w;
      r.event_res = lacd_pkg::EV_TRIGVALUE;
      r.stage     = st;
      r.arg_value = w;
    end else if (trig) begin
      setup_q[st]    = {w[27], w[26], w[24], w[23:20], w[17:16], w[15:0]};
      r.event_res    = lacd_pkg::EV_TRIGCFG;
      r.stage        = st;
      r.arg_value    = {16'd0, w[15:0]};
      r.trig_level   = w[17:16];
      r.trig_channel = {w[24], w[23:20]};
      r.trig_serial  = w[26];
      r.trig_start   = w[27];
    end else begin
      r.event_res = lacd_pkg::EV_UNK_LONG;
      r.arg_value = w;
    end
    return r;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_events.size() == 0) begin
        $error("result transaction with no expected event pending");
        mismatches++;
      end else begin
        want_res = expected_events.pop_front();
        results_checked++;
        check_field("event_res", 32'(want_res.event_res), 32'(event_res_o));
        check_field("stage", 32'(want_res.stage), 32'(stage_o));
        check_field("arg_value", want_res.arg_value, arg_value_o);
        check_field("trig_level", 32'(want_res.trig_level), 32'(trig_level_o));
        check_field("trig_channel", 32'(want_res.trig_channel), 32'(trig_channel_o));
        check_field("trig_serial", 32'(want_res.trig_serial), 32'(trig_serial_o));
        check_field("trig_start", 32'(want_res.trig_start), 32'(trig_start_o));
        check_field("group_off", 32'(want_res.group_off), 32'(group_off_o));
        check_field("flag_bits", 32'(want_res.flag_bits), 32'(flag_bits_o));
        check_field("rle_on", 32'(want_res.rle_on), 32'(rle_on_o));
      end
    end
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    expected_events.push_back(decode_byte(b));
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_short(input logic [7:0] op);
    send_byte(op);
    commands_sent++;
  endtask

  task automatic send_long(input logic [7:0] op, input logic [31:0] word);
    send_byte(op);
    for (int i = 0; i < 4; i++) send_byte(word[8 * i +: 8]);
    commands_sent++;
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic test_short_commands();
    send_short(lacd_pkg::OpReset);
    send_short(lacd_pkg::OpRun);
    send_short(lacd_pkg::OpId);
    send_short(lacd_pkg::OpMeta);
    send_short(8'h7F);
    send_short(8'h03);
  endtask

  task automatic test_long_commands();
    send_long(lacd_pkg::OpDivider, 32'hFFFF_FFFF);
    send_long(lacd_pkg::OpFlags, 32'h0000_01FF);
    send_long(lacd_pkg::OpTrigMsk, 32'hFFFF_FFFF);
    send_long(lacd_pkg::OpTrigVal | 8'h04, 32'hA5C3_5A3C);
    send_long(lacd_pkg::OpTrigCfg | 8'h0C, 32'hFFFF_FFFF);
  endtask

  task automatic test_special_cases();
    send_long(lacd_pkg::OpCounts, 32'h0000_0000);
    send_short(lacd_pkg::OpReset);
    send_long(8'hFF, 32'h1234_5678);
    send_long(lacd_pkg::OpTrigCfg | 8'h01, 32'h0000_0000);
  endtask

  task automatic test_drain_pause();
    send_byte(lacd_pkg::OpTrigVal | 8'h08);
    send_byte(8'h11);
    send_byte(8'h22);
    wait_for_drain();
    send_byte(8'h33);
    send_byte(8'h44);
    commands_sent++;
    wait_for_drain();
  endtask

  task automatic send_random_command();
    logic [1:0] st;
    logic [7:0] op;
    int         pick;
    st   = 2'($urandom_range(3));
    pick = $urandom_range(99);
    if (pick < 55) begin
      case ($urandom_range(5))
        0:       op = lacd_pkg::OpDivider;
        1:       op = lacd_pkg::OpCounts;
        2:       op = lacd_pkg::OpFlags;
        3:       op = lacd_pkg::OpTrigMsk | {4'd0, st, 2'd0};
        4:       op = lacd_pkg::OpTrigVal | {4'd0, st, 2'd0};
        default: op = lacd_pkg::OpTrigCfg | {4'd0, st, 2'd0};
      endcase
      send_long(op, pick_word());
    end else if (pick < 75) begin
      case ($urandom_range(4))
        0:       op = lacd_pkg::OpReset;
        1:       op = lacd_pkg::OpRun;
        2:       op = lacd_pkg::OpId;
        3:       op = lacd_pkg::OpMeta;
        default: op = 8'($urandom_range(127));
      endcase
      send_short(op);
    end else if (pick < 85) begin
      send_long(8'($urandom_range(255, 128)), pick_word());
    end else begin
      send_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic random_phase(input int gap, input int stall, input int n_bytes);
    int start_count;
    gap_pct     = gap;
    stall_pct   = stall;
    start_count = bytes_sent;
    while (bytes_sent - start_count < n_bytes) send_random_command();
  endtask

  task automatic test_random_traffic();
    random_phase(0, 0, 500);
    random_phase(50, 0, 500);
    random_phase(0, 50, 500);
    test_drain_pause();
    random_phase(27, 27, 500);
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    rx_byte_i       = '0;
    gap_pct         = 0;
    stall_pct       = 0;
    mismatches      = 0;
    results_checked = 0;
    bytes_sent      = 0;
    commands_sent   = 0;
    arg_pos         = '0;
    held_op         = '0;
    arg_word        = '0;
    divider_q       = '0;
    counts_q        = '0;
    flags_q         = '0;
    for (int i = 0; i < lacd_pkg::NumStages; i++) begin
      mask_q[i]  = '0;
      value_q[i] = '0;
      setup_q[i] = '0;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_short_commands();
    test_long_commands();
    test_special_cases();
    test_random_traffic();

    in_valid_i <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Covered %0d bytes in %0d commands: every opcode, a mid-command drain and",
             bytes_sent, commands_sent);
    $display("four gap and stall mixes; %0d results checked, %0d mismatches.",
             results_checked, mismatches);
    if (mismatches == 0) begin
      $display("logic_analyzer_command_decoder_top test passed");
    end else begin
      $display("logic_analyzer_command_decoder_top test failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/lacd_pkg.sv
hdl/lacd_frame.sv
hdl/lacd_decode.sv
hdl/logic_analyzer_command_decoder_top.sv
tb/tb_logic_analyzer_command_decoder_top.sv
